[rtl/blst_pkg.sv]
// Shared constants for the buffer lease slot tracker: pool size, derived
// widths, slot state codes and operation codes. No dependencies.
package blst_pkg;

    localparam int SLOTS = 8;                                   // 1 .. 64
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Field widths of the channels.
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 8;
    localparam int TOKEN_W = 64;
    localparam int GRANT_W = 3;
    localparam int COUNT_W = 4;
    localparam int STATE_W = 2;

    typedef logic [STATE_W-1:0] slot_state_t;

    localparam slot_state_t ST_FREE = 2'd0;
    localparam slot_state_t ST_CONV = 2'd1;
    localparam slot_state_t ST_SUBM = 2'd2;
    localparam slot_state_t ST_RETI = 2'd3;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ACQUIRE      = 3'd0;
    localparam op_t OP_RELEASE      = 3'd1;
    localparam op_t OP_SUBMIT       = 3'd2;
    localparam op_t OP_COMPLETE     = 3'd3;
    localparam op_t OP_RETIRE_ALL   = 3'd4;
    localparam op_t OP_FREE_RETIRED = 3'd5;
    localparam op_t OP_QUERY        = 3'd6;

endpackage

[rtl/buffer_lease_slot_tracker.sv]
// Buffer lease slot tracker: slot state table walked by one scan pointer
// with a single shared 64-bit token comparator. Depends on blst_pkg.
//
//  channel | dir | ports                                                      | beat
//  --------+-----+------------------------------------------------------------+-----------
//  s_      | in  | s_valid s_ready s_op s_slot s_token                        | one op
//  m_      | out | m_valid m_ready m_ok m_granted_slot m_*_count m_slot_state | one result
//
// Per beat: acquire, complete, retire all and free retired walk every slot
// once, then load the output. Submit walks every slot for the duplicate
// check, then writes the target slot. Release and query touch one slot.
// Unused op code seven goes straight to the output state.
// The scan pointer and its single comparator set this sequencing.
// Reset (aresetn low, synchronous) frees every slot and empties the output.
// s_ready is high only while idle; a finished beat waiting on m_ready holds the
// sequencer in its output state, and a new beat is taken once it has left.
module buffer_lease_slot_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // operation beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [blst_pkg::OP_W-1:0]         s_op,
    input  logic [blst_pkg::SLOT_W-1:0]       s_slot,
    input  logic [blst_pkg::TOKEN_W-1:0]      s_token,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [blst_pkg::GRANT_W-1:0]      m_granted_slot,
    output logic [blst_pkg::COUNT_W-1:0]      m_changed_count,
    output logic [blst_pkg::COUNT_W-1:0]      m_live_count,
    output logic [blst_pkg::COUNT_W-1:0]      m_free_count,
    output logic [blst_pkg::COUNT_W-1:0]      m_retired_count,
    output logic [blst_pkg::STATE_W-1:0]      m_slot_state
);

    localparam int IDX_W = blst_pkg::IDX_W;
    localparam int CNT_W = blst_pkg::CNT_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a beat
    localparam logic [1:0] S_SCAN  = 2'd1;  // pointer walks all slots
    localparam logic [1:0] S_APPLY = 2'd2;  // single access at the given slot
    localparam logic [1:0] S_OUT   = 2'd3;  // load result register

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(blst_pkg::SLOTS - 1);

    // Slot table
    blst_pkg::slot_state_t              status_reg [blst_pkg::SLOTS];
    logic [blst_pkg::TOKEN_W-1:0]       slot_tok_reg [blst_pkg::SLOTS];

    // Sequencer and latched beat
    logic [1:0]                         state_reg, state_next;
    logic [IDX_W-1:0]                   ptr_reg, ptr_next;
    blst_pkg::op_t                      op_reg;
    logic [blst_pkg::SLOT_W-1:0]        slot_reg;
    logic [blst_pkg::TOKEN_W-1:0]       tok_reg;

    // Per-beat result accumulators
    logic                               hit_reg, hit_next;   // granted / dup / matched
    logic                               ok_reg, ok_next;
    logic [IDX_W-1:0]                   grant_reg, grant_next;
    logic [CNT_W-1:0]                   chg_reg, chg_next;
    blst_pkg::slot_state_t              qstate_reg, qstate_next;

    // Running pool counts, kept current on each status write
    logic [CNT_W-1:0]                   free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]                   ret_cnt_reg, ret_cnt_next;

    // Output register
    logic                               m_valid_reg;
    logic                               m_ok_reg;
    logic [blst_pkg::GRANT_W-1:0]       m_grant_reg;
    logic [blst_pkg::COUNT_W-1:0]       m_chg_reg, m_live_reg, m_free_reg, m_ret_reg;
    blst_pkg::slot_state_t              m_qstate_reg;

    // Table write port, one slot per cycle at ptr_reg
    logic                               wr_en;
    blst_pkg::slot_state_t              wr_val;
    logic                               tok_wr_en;

    logic                               accept;
    logic                               in_range;
    logic                               out_free;
    blst_pkg::slot_state_t              cur;
    logic                               tok_match;
    logic                               ok_final;
    logic [7:0]                         grant_wide, chg_wide, live_wide, free_wide, ret_wide;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_range  = (slot_reg < blst_pkg::SLOT_W'(blst_pkg::SLOTS));
    assign out_free  = !m_valid_reg || m_ready;

    // Shared unit: the one status read and token compare at the pointer
    assign cur       = status_reg[ptr_reg];
    assign tok_match = (tok_reg == slot_tok_reg[ptr_reg]);

    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        ok_next     = ok_reg;
        grant_next  = grant_reg;
        chg_next    = chg_reg;
        qstate_next = qstate_reg;
        wr_en       = 1'b0;
        wr_val      = blst_pkg::ST_FREE;
        tok_wr_en   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    hit_next    = 1'b0;
                    ok_next     = 1'b0;
                    grant_next  = '0;
                    chg_next    = '0;
                    qstate_next = blst_pkg::ST_FREE;
                    ptr_next    = '0;
                    case (s_op)
                        blst_pkg::OP_ACQUIRE, blst_pkg::OP_SUBMIT,
                        blst_pkg::OP_COMPLETE, blst_pkg::OP_RETIRE_ALL,
                        blst_pkg::OP_FREE_RETIRED: begin
                            state_next = S_SCAN;
                        end
                        blst_pkg::OP_RELEASE, blst_pkg::OP_QUERY: begin
                            // out-of-range slot parks the pointer at zero
                            if (s_slot < blst_pkg::SLOT_W'(blst_pkg::SLOTS)) begin
                                ptr_next = s_slot[IDX_W-1:0];
                            end
                            state_next = S_APPLY;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (op_reg)
                    blst_pkg::OP_ACQUIRE: begin
                        // retired slots count as free: the sweep runs ahead of the grant
                        if (!hit_reg &&
                            (cur inside {blst_pkg::ST_FREE, blst_pkg::ST_RETI})) begin
                            wr_en      = 1'b1;
                            wr_val     = blst_pkg::ST_CONV;
                            hit_next   = 1'b1;
                            grant_next = ptr_reg;
                        end else if (cur == blst_pkg::ST_RETI) begin
                            wr_en  = 1'b1;
                            wr_val = blst_pkg::ST_FREE;
                        end
                    end
                    blst_pkg::OP_SUBMIT: begin
                        if (cur == blst_pkg::ST_SUBM && tok_match) begin
                            hit_next = 1'b1;
                        end
                    end
                    blst_pkg::OP_COMPLETE: begin
                        if (!hit_reg && cur == blst_pkg::ST_SUBM && tok_match) begin
                            wr_en    = 1'b1;
                            wr_val   = blst_pkg::ST_RETI;
                            hit_next = 1'b1;
                        end
                    end
                    blst_pkg::OP_RETIRE_ALL: begin
                        if (cur inside {blst_pkg::ST_CONV, blst_pkg::ST_SUBM}) begin
                            wr_en    = 1'b1;
                            wr_val   = blst_pkg::ST_RETI;
                            chg_next = chg_reg + CNT_W'(1);
                        end
                    end
                    blst_pkg::OP_FREE_RETIRED: begin
                        if (cur == blst_pkg::ST_RETI) begin
                            wr_en    = 1'b1;
                            wr_val   = blst_pkg::ST_FREE;
                            chg_next = chg_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase

                if (ptr_reg == LAST_IDX) begin
                    if (op_reg == blst_pkg::OP_SUBMIT) begin
                        ptr_next   = in_range ? slot_reg[IDX_W-1:0] : '0;
                        state_next = S_APPLY;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end

            S_APPLY: begin
                if (in_range) begin
                    case (op_reg)
                        blst_pkg::OP_RELEASE: begin
                            if (cur == blst_pkg::ST_CONV) begin
                                wr_en   = 1'b1;
                                wr_val  = blst_pkg::ST_FREE;
                                ok_next = 1'b1;
                            end
                        end
                        blst_pkg::OP_SUBMIT: begin
                            // hit_reg holds the duplicate flag from the scan
                            if (cur == blst_pkg::ST_CONV && !hit_reg) begin
                                wr_en     = 1'b1;
                                wr_val    = blst_pkg::ST_SUBM;
                                tok_wr_en = 1'b1;
                                ok_next   = 1'b1;
                            end
                        end
                        blst_pkg::OP_QUERY: begin
                            qstate_next = cur;
                            ok_next     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                state_next = S_OUT;
            end

            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pool counts follow the single write; live is the complement of free
    always_comb begin
        free_cnt_next = free_cnt_reg;
        ret_cnt_next  = ret_cnt_reg;
        if (wr_en) begin
            free_cnt_next = free_cnt_reg - CNT_W'(cur == blst_pkg::ST_FREE)
                                         + CNT_W'(wr_val == blst_pkg::ST_FREE);
            ret_cnt_next  = ret_cnt_reg - CNT_W'(cur == blst_pkg::ST_RETI)
                                        + CNT_W'(wr_val == blst_pkg::ST_RETI);
        end
    end

    always_comb begin
        case (op_reg)
            blst_pkg::OP_ACQUIRE, blst_pkg::OP_COMPLETE:       ok_final = hit_reg;
            blst_pkg::OP_RETIRE_ALL, blst_pkg::OP_FREE_RETIRED: ok_final = 1'b1;
            blst_pkg::OP_RELEASE, blst_pkg::OP_SUBMIT,
            blst_pkg::OP_QUERY:                                ok_final = ok_reg;
            default:                                           ok_final = 1'b0;
        endcase
    end

    // Fields are masked to their port widths when the pool is larger
    assign grant_wide = 8'(grant_reg);
    assign chg_wide   = 8'(chg_reg);
    assign free_wide  = 8'(free_cnt_reg);
    assign ret_wide   = 8'(ret_cnt_reg);
    assign live_wide  = 8'(CNT_W'(blst_pkg::SLOTS) - free_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            hit_reg      <= 1'b0;
            ok_reg       <= 1'b0;
            free_cnt_reg <= CNT_W'(blst_pkg::SLOTS);
            ret_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < blst_pkg::SLOTS; i++) begin
                status_reg[i] <= blst_pkg::ST_FREE;
            end
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            hit_reg      <= hit_next;
            ok_reg       <= ok_next;
            free_cnt_reg <= free_cnt_next;
            ret_cnt_reg  <= ret_cnt_next;
            if (wr_en) begin
                status_reg[ptr_reg] <= wr_val;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        grant_reg  <= grant_next;
        chg_reg    <= chg_next;
        qstate_reg <= qstate_next;
        if (accept) begin
            op_reg   <= s_op;
            slot_reg <= s_slot;
            tok_reg  <= s_token;
        end
        if (tok_wr_en) begin
            slot_tok_reg[ptr_reg] <= tok_reg;
        end
        if (state_reg == S_OUT && out_free) begin
            m_ok_reg     <= ok_final;
            m_grant_reg  <= grant_wide[blst_pkg::GRANT_W-1:0];
            m_chg_reg    <= chg_wide[blst_pkg::COUNT_W-1:0];
            m_live_reg   <= live_wide[blst_pkg::COUNT_W-1:0];
            m_free_reg   <= free_wide[blst_pkg::COUNT_W-1:0];
            m_ret_reg    <= ret_wide[blst_pkg::COUNT_W-1:0];
            m_qstate_reg <= qstate_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_granted_slot  = m_grant_reg;
    assign m_changed_count = m_chg_reg;
    assign m_live_count    = m_live_reg;
    assign m_free_count    = m_free_reg;
    assign m_retired_count = m_ret_reg;
    assign m_slot_state    = m_qstate_reg;

endmodule

[rtl/blst_checker.sv]
// Port-level checks for buffer_lease_slot_tracker, attached by bind.
// Depends on blst_pkg.
module blst_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_ok,
    input  logic [blst_pkg::GRANT_W-1:0]      m_granted_slot,
    input  logic [blst_pkg::COUNT_W-1:0]      m_live_count,
    input  logic [blst_pkg::COUNT_W-1:0]      m_free_count
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one beat at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    // every slot is either free or live
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (4'(m_live_count + m_free_count) == 4'(blst_pkg::SLOTS)))
        else $error("live plus free differs from pool size");

    // a grant only comes with success
    a_grant_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_granted_slot == '0)
        else $error("nonzero grant on failed beat");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_live_count))
        else $error("stalled result changed");

endmodule

bind buffer_lease_slot_tracker blst_checker u_blst_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_ok           (m_ok),
    .m_granted_slot (m_granted_slot),
    .m_live_count   (m_live_count),
    .m_free_count   (m_free_count)
);

[dv/tb_buffer_lease_slot_tracker.sv]
// Self-checking bench for buffer_lease_slot_tracker: directed, random and
// backpressure beats, scored against a lease table kept in the bench.
// Depends on blst_pkg and rtl/buffer_lease_slot_tracker.sv.
module tb_buffer_lease_slot_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = blst_pkg::SLOTS;
    localparam int OP_W    = blst_pkg::OP_W;
    localparam int SLOT_W  = blst_pkg::SLOT_W;
    localparam int TOKEN_W = blst_pkg::TOKEN_W;
    localparam int GRANT_W = blst_pkg::GRANT_W;
    localparam int COUNT_W = blst_pkg::COUNT_W;
    localparam int STATE_W = blst_pkg::STATE_W;

    // Op code seven is unused by the block; it must report counts only.
    localparam blst_pkg::op_t OP_UNUSED = 3'd7;

    localparam int DRAIN_CYCLES = 12;   // margin after the slowest op (submit)
    localparam int STALL_CYCLES = 80;   // long receiver hold-off

    typedef struct {
        logic                   ok;
        logic [GRANT_W-1:0]     granted;
        logic [COUNT_W-1:0]     changed;
        logic [COUNT_W-1:0]     live;
        logic [COUNT_W-1:0]     nfree;
        logic [COUNT_W-1:0]     retired;
        blst_pkg::slot_state_t  state;
    } lease_result_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op    = '0;
    logic [SLOT_W-1:0]    s_slot  = '0;
    logic [TOKEN_W-1:0]   s_token = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_ok;
    logic [GRANT_W-1:0]   m_granted_slot;
    logic [COUNT_W-1:0]   m_changed_count;
    logic [COUNT_W-1:0]   m_live_count;
    logic [COUNT_W-1:0]   m_free_count;
    logic [COUNT_W-1:0]   m_retired_count;
    logic [STATE_W-1:0]   m_slot_state;

    // Bench copy of the lease table, advanced once per accepted op beat.
    blst_pkg::slot_state_t lease_state [SLOTS];
    logic [TOKEN_W-1:0]    lease_token [SLOTS];
    lease_result_t         pending_results [$];

    int mismatches    = 0;
    int src_idle_pct  = 0;    // chance per cycle that the sender holds off
    int sink_idle_pct = 0;    // chance per cycle that m_ready drops
    logic stall_kick  = 1'b0; // one-cycle pulse starts the long hold-off
    int   stall_left  = 0;

    buffer_lease_slot_tracker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_slot          (s_slot),
        .s_token         (s_token),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_granted_slot  (m_granted_slot),
        .m_changed_count (m_changed_count),
        .m_live_count    (m_live_count),
        .m_free_count    (m_free_count),
        .m_retired_count (m_retired_count),
        .m_slot_state    (m_slot_state)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Lease table model
    // ------------------------------------------------------------------

    // Frees every retired slot, returns how many were freed.
    function automatic int sweep_retired_leases();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (lease_state[i] == blst_pkg::ST_RETI) begin
                lease_state[i] = blst_pkg::ST_FREE;
                lease_token[i] = '0;
                n++;
            end
        end
        return n;
    endfunction

    function automatic lease_result_t predict_lease(blst_pkg::op_t op,
                                                    logic [SLOT_W-1:0] slot,
                                                    logic [TOKEN_W-1:0] tok);
        lease_result_t r;
        bit in_range;
        bit dup;
        int changed;
        int live;
        int nfree;
        int nret;
        r        = '{ok: 1'b0, granted: '0, changed: '0, live: '0, nfree: '0,
                     retired: '0, state: blst_pkg::ST_FREE};
        in_range = (slot < SLOTS);
        dup      = 1'b0;
        changed  = 0;
        live     = 0;
        nfree    = 0;
        nret     = 0;
        case (op)
            blst_pkg::OP_ACQUIRE: begin
                // retired slots go back to the pool before the search
                void'(sweep_retired_leases());
                for (int i = 0; i < SLOTS; i++) begin
                    if (!r.ok && lease_state[i] == blst_pkg::ST_FREE) begin
                        lease_state[i] = blst_pkg::ST_CONV;
                        lease_token[i] = '0;
                        r.ok           = 1'b1;
                        r.granted      = GRANT_W'(i);
                    end
                end
            end
            blst_pkg::OP_RELEASE: begin
                if (in_range && lease_state[slot] == blst_pkg::ST_CONV) begin
                    lease_state[slot] = blst_pkg::ST_FREE;
                    lease_token[slot] = '0;
                    r.ok              = 1'b1;
                end
            end
            blst_pkg::OP_SUBMIT: begin
                if (in_range && lease_state[slot] == blst_pkg::ST_CONV) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (lease_state[i] == blst_pkg::ST_SUBM && lease_token[i] == tok)
                            dup = 1'b1;
                    if (!dup) begin
                        lease_state[slot] = blst_pkg::ST_SUBM;
                        lease_token[slot] = tok;
                        r.ok              = 1'b1;
                    end
                end
            end
            blst_pkg::OP_COMPLETE: begin
                // lowest matching submitted slot only
                for (int i = 0; i < SLOTS; i++) begin
                    if (!r.ok && lease_state[i] == blst_pkg::ST_SUBM &&
                        lease_token[i] == tok) begin
                        lease_state[i] = blst_pkg::ST_RETI;
                        r.ok           = 1'b1;
                    end
                end
            end
            blst_pkg::OP_RETIRE_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (lease_state[i] == blst_pkg::ST_CONV ||
                        lease_state[i] == blst_pkg::ST_SUBM) begin
                        lease_state[i] = blst_pkg::ST_RETI;
                        changed++;
                    end
                end
                r.ok = 1'b1;
            end
            blst_pkg::OP_FREE_RETIRED: begin
                changed = sweep_retired_leases();
                r.ok    = 1'b1;
            end
            blst_pkg::OP_QUERY: begin
                if (in_range) begin
                    r.state = lease_state[slot];
                    r.ok    = 1'b1;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            if (lease_state[i] == blst_pkg::ST_FREE) nfree++;
            else                                     live++;
            if (lease_state[i] == blst_pkg::ST_RETI) nret++;
        end
        r.changed = COUNT_W'(changed);
        r.live    = COUNT_W'(live);
        r.nfree   = COUNT_W'(nfree);
        r.retired = COUNT_W'(nret);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Op sender: optional idle gap, then hold the beat until s_ready.
    // valid is only lowered inside a gap, so back-to-back beats keep it high.
    // ------------------------------------------------------------------
    task automatic send_op(blst_pkg::op_t op, logic [SLOT_W-1:0] slot,
                           logic [TOKEN_W-1:0] tok);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_slot  <= slot;
        s_token <= tok;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_lease(op, slot, tok));
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: score accepted beats, then pick next m_ready.
    // Values read here are the ones sampled at this edge.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [TOKEN_W-1:0] want, logic [TOKEN_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        lease_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, ok %0d", $time, m_ok);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", TOKEN_W'(want.ok), TOKEN_W'(m_ok));
                check_field("granted_slot", TOKEN_W'(want.granted),
                            TOKEN_W'(m_granted_slot));
                check_field("changed_count", TOKEN_W'(want.changed),
                            TOKEN_W'(m_changed_count));
                check_field("live_count", TOKEN_W'(want.live), TOKEN_W'(m_live_count));
                check_field("free_count", TOKEN_W'(want.nfree), TOKEN_W'(m_free_count));
                check_field("retired_count", TOKEN_W'(want.retired),
                            TOKEN_W'(m_retired_count));
                check_field("slot_state", TOKEN_W'(want.state), TOKEN_W'(m_slot_state));
            end
        end
        m_ready <= (stall_left == 0) && ($urandom_range(99) >= sink_idle_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing.
    always @(posedge aclk) begin
        if (stall_kick)          stall_left <= STALL_CYCLES;
        else if (stall_left > 0) stall_left <= stall_left - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random slot currently in the given state, or -1 if none.
    function automatic int pick_slot(blst_pkg::slot_state_t st);
        int start;
        int idx;
        start = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            idx = (start + i) % SLOTS;
            if (lease_state[idx] == st) return idx;
        end
        return -1;
    endfunction

    // Mostly small tokens so duplicate submits and completes collide often.
    function automatic logic [TOKEN_W-1:0] rand_token();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)      return '0;
        else if (roll < 20) return '1;
        else if (roll < 70) return TOKEN_W'($urandom_range(1, 6));
        else                return {$urandom, $urandom};
    endfunction

    // In range most of the time; the rest spans every bit of the field.
    function automatic logic [SLOT_W-1:0] rand_slot();
        if ($urandom_range(99) < 85) return SLOT_W'($urandom_range(SLOTS - 1));
        return SLOT_W'($urandom_range(SLOTS, 255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walks the pool through every op and every corner of the lease rules.
    task automatic test_directed();
        send_op(blst_pkg::OP_QUERY, 8'd0, '0);              // fresh slot reads free
        send_op(blst_pkg::OP_QUERY, 8'd255, '1);            // out of range query
        send_op(OP_UNUSED, 8'd0, '0);                       // no change, counts only
        repeat (SLOTS) send_op(blst_pkg::OP_ACQUIRE, 8'd0, '0);
        send_op(blst_pkg::OP_ACQUIRE, 8'd0, '0);            // pool exhausted
        send_op(blst_pkg::OP_SUBMIT, 8'd0, '0);
        send_op(blst_pkg::OP_SUBMIT, 8'd1, '1);
        send_op(blst_pkg::OP_SUBMIT, 8'd2, '0);             // duplicate live token
        send_op(blst_pkg::OP_SUBMIT, 8'd8, 64'd9);          // just past the pool
        send_op(blst_pkg::OP_RELEASE, 8'd255, '0);          // out of range release
        send_op(blst_pkg::OP_RELEASE, 8'd3, '0);            // converting slot frees
        send_op(blst_pkg::OP_RELEASE, 8'd0, '0);            // submitted slot cannot
        send_op(blst_pkg::OP_ACQUIRE, 8'd0, '0);            // refills slot 3
        send_op(blst_pkg::OP_COMPLETE, 8'd0, '1);           // retires slot 1
        send_op(blst_pkg::OP_COMPLETE, 8'd0, 64'd5);        // no match
        send_op(blst_pkg::OP_QUERY, 8'd1, '0);              // retired
        send_op(blst_pkg::OP_RETIRE_ALL, 8'd0, '0);         // whole pool retired now
        send_op(blst_pkg::OP_ACQUIRE, 8'd0, '0);            // sweep makes room
        send_op(blst_pkg::OP_RETIRE_ALL, 8'd0, '0);
        send_op(blst_pkg::OP_FREE_RETIRED, 8'd0, '0);
        wait_for_drain();
    endtask

    // Mostly coherent lease traffic aimed at slots in the right state,
    // with some blind ops and the unused code as noise.
    task automatic test_random_ops(int count);
        int roll;
        int pick;
        blst_pkg::op_t op;
        logic [SLOT_W-1:0]  slot;
        logic [TOKEN_W-1:0] tok;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            slot = rand_slot();
            tok  = rand_token();
            if (roll < 22)      op = blst_pkg::OP_ACQUIRE;
            else if (roll < 32) op = blst_pkg::OP_RELEASE;
            else if (roll < 56) op = blst_pkg::OP_SUBMIT;
            else if (roll < 74) op = blst_pkg::OP_COMPLETE;
            else if (roll < 78) op = blst_pkg::OP_RETIRE_ALL;
            else if (roll < 84) op = blst_pkg::OP_FREE_RETIRED;
            else if (roll < 96) op = blst_pkg::OP_QUERY;
            else                op = OP_UNUSED;
            if ((op == blst_pkg::OP_SUBMIT || op == blst_pkg::OP_RELEASE) &&
                $urandom_range(99) < 75) begin
                pick = pick_slot(blst_pkg::ST_CONV);
                if (pick >= 0) slot = SLOT_W'(pick);
            end
            if (op == blst_pkg::OP_COMPLETE && $urandom_range(99) < 70) begin
                pick = pick_slot(blst_pkg::ST_SUBM);
                if (pick >= 0) tok = lease_token[pick];
            end
            send_op(op, slot, tok);
        end
        wait_for_drain();
    endtask

    // Receiver holds off for a long stretch while ops keep coming, so the
    // pending result blocks the sequencer and s_ready stays low.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_kick <= 1'b1;
        @(posedge aclk);
        stall_kick <= 1'b0;
        for (int n = 0; n < 12; n++)
            send_op((n % 3 == 0) ? blst_pkg::OP_ACQUIRE : blst_pkg::OP_QUERY,
                    rand_slot(), rand_token());
        wait_for_drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            lease_state[i] = blst_pkg::ST_FREE;
            lease_token[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();

        src_idle_pct  = 16;
        sink_idle_pct = 74;
        test_random_ops(180);

        src_idle_pct  = 74;
        sink_idle_pct = 16;
        test_random_ops(180);

        test_backpressure();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_ops(180);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hang guard: stops a run that has not finished by the timeout.
    initial begin
        #2_000_000;
        $display("%0t ns: timeout, %0d results still expected", $time,
                 pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
